[rtl/encoder_rpm_pid_motor_drive_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wheel speed controller
// Shared forms for the concurrent checks, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_RPM_PID_MOTOR_DRIVE_CORE_ASSERT_SVH
`define ENCODER_RPM_PID_MOTOR_DRIVE_CORE_ASSERT_SVH

// Same-cycle implication.
`define ERPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ERPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/erpm_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel speed controller package
// Widths, constants and the request and response types of the serial units.
// ----------------------------------------------------------------------------
`default_nettype none

package erpm_pkg;

  // Serial multiplier: signed multiplicand, unsigned multiplier taken one bit a cycle.
  localparam int unsigned MUL_A_W   = 58;
  localparam int unsigned MUL_B_W   = 24;
  localparam int unsigned MUL_STEPS = MUL_B_W;

  // Serial divider: unsigned, one quotient bit a cycle.
  localparam int unsigned DIV_N_W   = 56;
  localparam int unsigned DIV_D_W   = 32;
  localparam int unsigned DIV_STEPS = DIV_N_W;

  // 60000 ms per minute times 256 for the Q12.8 result.
  localparam logic [MUL_B_W-1:0] SPEED_SCALE = 24'd15360000;
  localparam logic [DIV_D_W-1:0] DUTY_FULL   = 32'd255;

  localparam logic signed [19:0] SPD_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] SPD_MIN = 20'sh80000;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_I = 3'd1,
    REG_GAIN_D = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_CPT    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic        [MUL_B_W-1:0] b;
  } erpm_mul_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [MUL_A_W-1:0] prod;
  } erpm_mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } erpm_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quo;
  } erpm_div_rsp_t;

endpackage

`default_nettype wire

[rtl/erpm_mul.sv]
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module erpm_mul
  import erpm_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire erpm_mul_req_t req_i,
  output erpm_mul_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(MUL_STEPS);

  logic                      busy_q, done_q;
  logic [CntW-1:0]           cnt_q;
  logic signed [MUL_A_W-1:0] a_q, acc_q;
  logic        [MUL_B_W-1:0] b_q;

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(MUL_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand shifting and accumulation.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

[rtl/erpm_div.sv]
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned division, one quotient bit per cycle, full-width quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module erpm_div
  import erpm_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire erpm_div_req_t req_i,
  output erpm_div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DIV_D_W-1:0]   rem_q, den_q;
  logic [DIV_N_W-1:0]   dq_q;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted = {rem_q, dq_q[DIV_N_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = ~diff[DIV_D_W+1];

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient share one shift path.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dq_q  <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      dq_q  <= {dq_q[DIV_N_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dq_q;

endmodule

`default_nettype wire

[rtl/encoder_rpm_pid_motor_drive_core.sv]
// ----------------------------------------------------------------------------
// Encoder speed PID motor drive
// Measures wheel rpm from encoder counts and runs a PID update to a PWM duty.
// ----------------------------------------------------------------------------
// One input transfer yields one output transfer when the result side is
// ready: six products on a shared shift-add multiplier (one multiplier bit
// per cycle) and up to three quotients on a shared restoring divider (one
// quotient bit per cycle). The speed division is skipped when the elapsed
// time or counts per turn is zero, and the duty division when the speed
// limit is zero. A new item is taken once the previous one has reached the
// output register, even while that result still waits to be taken.
`default_nettype none

`include "encoder_rpm_pid_motor_drive_core_assert.svh"

module encoder_rpm_pid_motor_drive_core
  import erpm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] encoder_count, [47:32] elapsed_ms, [67:48] target_speed
  input  wire logic [71:0] s_axis_tdata,
  // Result item.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] duty_level, [27:8] measured_speed
  output logic [31:0]      m_axis_tdata,
  // [0] reverse
  output logic [0:0]       m_axis_tuser,
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MNUM  = 13'b0000000000010,
    S_MDEN  = 13'b0000000000100,
    S_DIVM  = 13'b0000000001000,
    S_ERR   = 13'b0000000010000,
    S_MP    = 13'b0000000100000,
    S_MI    = 13'b0000001000000,
    S_MD    = 13'b0000010000000,
    S_MB    = 13'b0000100000000,
    S_DB    = 13'b0001000000000,
    S_CLAMP = 13'b0010000000000,
    S_DD    = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, cpt_q;
  logic [10:0] limit_q;

  // Architectural state.
  logic signed [31:0] last_count_q, last_count_d;
  logic signed [31:0] error_sum_q, error_sum_d;
  logic signed [20:0] last_error_q, last_error_d;
  logic signed [8:0]  signed_duty_q, signed_duty_d;

  // Working registers of one item.
  logic               dneg_q, dneg_d;
  logic               bneg_q, bneg_d;
  logic [15:0]        dt_q, dt_d;
  logic signed [19:0] tgt_q, tgt_d;
  logic [55:0]        num_q, num_d;
  logic signed [19:0] meas_q, meas_d;
  logic signed [21:0] derr_q, derr_d;
  logic signed [49:0] pid_q, pid_d;
  logic signed [50:0] nw_q, nw_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic [7:0]         out_duty_q;
  logic               out_rev_q;
  logic signed [19:0] out_meas_q;
  logic [8:0]         sd_mag;

  erpm_mul_req_t mul_req;
  erpm_mul_rsp_t mul_rsp;
  erpm_div_req_t div_req;
  erpm_div_rsp_t div_rsp;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  erpm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  erpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 16'd154;
      gain_i_q <= 16'd77;
      gain_d_q <= 16'd128;
      limit_q  <= 11'd330;
      cpt_q    <= 16'd3000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P: gain_p_q <= pwdata[15:0];
        REG_GAIN_I: gain_i_q <= pwdata[15:0];
        REG_GAIN_D: gain_d_q <= pwdata[15:0];
        REG_LIMIT:  limit_q  <= pwdata[10:0];
        REG_CPT:    cpt_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P: prdata = {16'd0, gain_p_q};
      REG_GAIN_I: prdata = {16'd0, gain_i_q};
      REG_GAIN_D: prdata = {16'd0, gain_d_q};
      REG_LIMIT:  prdata = {21'd0, limit_q};
      REG_CPT:    prdata = {16'd0, cpt_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer and datapath.
  always_comb begin
    logic signed [32:0] delta;
    logic [32:0]        dmag;
    logic signed [20:0] err;
    logic signed [32:0] sum_w;
    logic [19:0]        bmag;
    logic signed [50:0] base;
    logic signed [50:0] lim_s;
    logic signed [50:0] nw_c;
    logic [26:0]        nmag;
    logic [34:0]        nx;
    logic [8:0]         q9;
    logic [55:0]        quo;

    state_d       = state_q;
    last_count_d  = last_count_q;
    error_sum_d   = error_sum_q;
    last_error_d  = last_error_q;
    signed_duty_d = signed_duty_q;
    dneg_d        = dneg_q;
    bneg_d        = bneg_q;
    dt_d          = dt_q;
    tgt_d         = tgt_q;
    num_d         = num_q;
    meas_d        = meas_q;
    derr_d        = derr_q;
    pid_d         = pid_q;
    nw_d          = nw_q;
    out_valid_d   = out_valid_q;
    out_load      = 1'b0;
    mul_req       = '0;
    div_req       = '0;

    delta = {s_axis_tdata[31], s_axis_tdata[31:0]} - {last_count_q[31], last_count_q};
    dmag  = delta[32] ? (~delta + 33'd1) : delta;
    err   = {tgt_q[19], tgt_q} - {meas_q[19], meas_q};
    sum_w = {error_sum_q[31], error_sum_q} + {{12{err[20]}}, err};
    quo   = div_rsp.quo;
    bmag  = mul_rsp.prod[MUL_A_W-1] ? (~mul_rsp.prod[19:0] + 20'd1) : mul_rsp.prod[19:0];
    base  = {23'd0, quo[27:0]};
    if (bneg_q) begin
      base = -base;
    end
    lim_s = {24'd0, limit_q, 16'd0};
    if (nw_q > lim_s) begin
      nw_c = lim_s;
    end else if (nw_q < -lim_s) begin
      nw_c = -lim_s;
    end else begin
      nw_c = nw_q;
    end
    nmag = nw_c[50] ? (~nw_c[26:0] + 27'd1) : nw_c[26:0];
    nx   = {nmag, 8'd0} - {8'd0, nmag};
    q9   = quo[8:0];

    // The output register empties on a transfer.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          dneg_d       = delta[32];
          dt_d         = s_axis_tdata[47:32];
          tgt_d        = s_axis_tdata[67:48];
          last_count_d = s_axis_tdata[31:0];
          mul_req.start = 1'b1;
          mul_req.a     = {{(MUL_A_W-33){1'b0}}, dmag};
          mul_req.b     = SPEED_SCALE;
          state_d       = S_MNUM;
        end
      end
      S_MNUM: begin
        if (mul_rsp.done) begin
          num_d         = mul_rsp.prod[55:0];
          mul_req.start = 1'b1;
          mul_req.a     = {{(MUL_A_W-16){1'b0}}, cpt_q};
          mul_req.b     = {8'd0, dt_q};
          state_d       = S_MDEN;
        end
      end
      S_MDEN: begin
        if (mul_rsp.done) begin
          if (mul_rsp.prod[31:0] == 32'd0) begin
            meas_d  = '0;
            state_d = S_ERR;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = num_q;
            div_req.divisor  = mul_rsp.prod[31:0];
            state_d          = S_DIVM;
          end
        end
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          if (dneg_q) begin
            meas_d = (quo > 56'd524288) ? SPD_MIN : (~quo[19:0] + 20'd1);
          end else begin
            meas_d = (quo > 56'd524287) ? SPD_MAX : quo[19:0];
          end
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        if (sum_w[32] != sum_w[31]) begin
          error_sum_d = sum_w[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
          error_sum_d = sum_w[31:0];
        end
        derr_d        = {err[20], err} - {last_error_q[20], last_error_q};
        last_error_d  = err;
        mul_req.start = 1'b1;
        mul_req.a     = {{(MUL_A_W-21){err[20]}}, err};
        mul_req.b     = {8'd0, gain_p_q};
        state_d       = S_MP;
      end
      S_MP: begin
        if (mul_rsp.done) begin
          pid_d         = mul_rsp.prod[49:0];
          mul_req.start = 1'b1;
          mul_req.a     = {{(MUL_A_W-32){error_sum_q[31]}}, error_sum_q};
          mul_req.b     = {8'd0, gain_i_q};
          state_d       = S_MI;
        end
      end
      S_MI: begin
        if (mul_rsp.done) begin
          pid_d         = pid_q + mul_rsp.prod[49:0];
          mul_req.start = 1'b1;
          mul_req.a     = {{(MUL_A_W-22){derr_q[21]}}, derr_q};
          mul_req.b     = {8'd0, gain_d_q};
          state_d       = S_MD;
        end
      end
      S_MD: begin
        if (mul_rsp.done) begin
          pid_d         = pid_q + mul_rsp.prod[49:0];
          mul_req.start = 1'b1;
          mul_req.a     = {{(MUL_A_W-9){signed_duty_q[8]}}, signed_duty_q};
          mul_req.b     = {13'd0, limit_q};
          state_d       = S_MB;
        end
      end
      S_MB: begin
        if (mul_rsp.done) begin
          bneg_d           = mul_rsp.prod[MUL_A_W-1];
          div_req.start    = 1'b1;
          div_req.dividend = {20'd0, bmag, 16'd0};
          div_req.divisor  = DUTY_FULL;
          state_d          = S_DB;
        end
      end
      S_DB: begin
        if (div_rsp.done) begin
          nw_d    = base + {pid_q[49], pid_q};
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (limit_q == 11'd0) begin
          signed_duty_d = '0;
          state_d       = S_OUT;
        end else begin
          bneg_d           = nw_c[50];
          div_req.start    = 1'b1;
          div_req.dividend = {37'd0, nx[34:16]};
          div_req.divisor  = {21'd0, limit_q};
          state_d          = S_DD;
        end
      end
      S_DD: begin
        if (div_rsp.done) begin
          signed_duty_d = bneg_q ? (~q9 + 9'd1) : q9;
          state_d       = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      last_count_q  <= '0;
      error_sum_q   <= '0;
      last_error_q  <= '0;
      signed_duty_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      last_count_q  <= last_count_d;
      error_sum_q   <= error_sum_d;
      last_error_q  <= last_error_d;
      signed_duty_q <= signed_duty_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    dneg_q <= dneg_d;
    bneg_q <= bneg_d;
    dt_q   <= dt_d;
    tgt_q  <= tgt_d;
    num_q  <= num_d;
    meas_q <= meas_d;
    derr_q <= derr_d;
    pid_q  <= pid_d;
    nw_q   <= nw_d;
  end

  // Output register.
  assign sd_mag = signed_duty_q[8] ? (~signed_duty_q + 9'd1) : signed_duty_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_duty_q <= sd_mag[7:0];
      out_rev_q  <= signed_duty_q[8];
      out_meas_q <= meas_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_meas_q, out_duty_q};
  assign m_axis_tuser  = out_rev_q;

  // Checks.
  `ERPM_ASSERT_IMP(a_mul_free, mul_req.start, !mul_rsp.busy, "multiplier started while busy")
  `ERPM_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `ERPM_ASSERT_IMP(a_duty_rng, 1'b1, (signed_duty_q <= 9'sd255) && (signed_duty_q >= -9'sd255), "duty out of range")
  `ERPM_ASSERT_IMP(a_out_free, out_load, !out_valid_q || m_axis_tready, "result overwritten")
  `ERPM_ASSERT_NXT(a_out_next, out_load, m_axis_tvalid && (state_q == S_IDLE), "result not presented")

endmodule

`default_nettype wire
